### design/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

    // Default operand width; denominators carry one bit less.
    localparam int unsigned OPERAND_BITS_DEF = 16;

    localparam int unsigned OP_W = 2;
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    // Any code with this bit set multiplies.
    localparam int unsigned OP_MUL_BIT = 1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DEN_ZERO = 1'b1;

    localparam int unsigned PC_W = 4;

    // Program step addresses used by the microprogram and its checks.
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK    = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_T1   = 4'd2;
    localparam logic [PC_W-1:0] STEP_MUL_T2   = 4'd3;
    localparam logic [PC_W-1:0] STEP_MUL_DEN  = 4'd4;
    localparam logic [PC_W-1:0] STEP_COMBINE  = 4'd5;
    localparam logic [PC_W-1:0] STEP_GCD_INIT = 4'd6;
    localparam logic [PC_W-1:0] STEP_GCD      = 4'd7;
    localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd8;
    localparam logic [PC_W-1:0] STEP_DIV_NUM  = 4'd9;
    localparam logic [PC_W-1:0] STEP_DIV_NEXT = 4'd10;
    localparam logic [PC_W-1:0] STEP_DIV_DEN  = 4'd11;
    localparam logic [PC_W-1:0] STEP_OUT_OK   = 4'd12;
    localparam logic [PC_W-1:0] STEP_OUT_ERR  = 4'd14;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD,
        ACT_MUL_T1,
        ACT_MUL_T2,
        ACT_MUL_DEN,
        ACT_COMBINE,
        ACT_GCD_INIT,
        ACT_GCD_STEP,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_DIV_NEXT,
        ACT_OUT_OK,
        ACT_OUT_ERR
    } action_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DEN_ZERO,
        COND_GCD_BUSY,
        COND_DIV_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        action_t         action;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic den_zero;
        logic gcd_busy;
        logic div_last;
        logic out_full;
    } dp_flags_t;

    // Microprogram. The next step is the target when the condition holds,
    // otherwise the following address.
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            STEP_IDLE:     w = '{ACT_LOAD,     COND_NO_INPUT, STEP_IDLE};
            STEP_CHECK:    w = '{ACT_NOP,      COND_DEN_ZERO, STEP_OUT_ERR};
            STEP_MUL_T1:   w = '{ACT_MUL_T1,   COND_NEVER,    STEP_IDLE};
            STEP_MUL_T2:   w = '{ACT_MUL_T2,   COND_NEVER,    STEP_IDLE};
            STEP_MUL_DEN:  w = '{ACT_MUL_DEN,  COND_NEVER,    STEP_IDLE};
            STEP_COMBINE:  w = '{ACT_COMBINE,  COND_NEVER,    STEP_IDLE};
            STEP_GCD_INIT: w = '{ACT_GCD_INIT, COND_NEVER,    STEP_IDLE};
            STEP_GCD:      w = '{ACT_GCD_STEP, COND_GCD_BUSY, STEP_GCD};
            STEP_DIV_INIT: w = '{ACT_DIV_INIT, COND_NEVER,    STEP_IDLE};
            STEP_DIV_NUM:  w = '{ACT_DIV_STEP, COND_DIV_MORE, STEP_DIV_NUM};
            STEP_DIV_NEXT: w = '{ACT_DIV_NEXT, COND_NEVER,    STEP_IDLE};
            STEP_DIV_DEN:  w = '{ACT_DIV_STEP, COND_DIV_MORE, STEP_DIV_DEN};
            STEP_OUT_OK:   w = '{ACT_OUT_OK,   COND_OUT_FULL, STEP_OUT_OK};
            STEP_OUT_ERR:  w = '{ACT_OUT_ERR,  COND_OUT_FULL, STEP_OUT_ERR};
            // The step after each result write returns to idle.
            default:       w = '{ACT_NOP,      COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/rau_in_if.sv
`timescale 1ns / 1ps

interface rau_in_if import rau_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [OP_W-1:0]                op;
    logic signed [OPERAND_BITS-1:0] num_a;
    logic [OPERAND_BITS-2:0]        den_a;
    logic signed [OPERAND_BITS-1:0] num_b;
    logic [OPERAND_BITS-2:0]        den_b;

    modport source (output valid, op, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, op, num_a, den_a, num_b, den_b, output ready);
endinterface

### design/rau_out_if.sv
`timescale 1ns / 1ps

interface rau_out_if import rau_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [2*OPERAND_BITS+1:0]   res_num;
    logic [2*OPERAND_BITS-3:0]          res_den;
    logic                               status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### design/rau_sequencer.sv
`timescale 1ns / 1ps

module rau_sequencer import rau_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_flags_t  flags,
    output ctrl_word_t ctrl,
    output logic       in_ready
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;

    assign ctrl     = ucode_rom(pc_reg);
    assign in_ready = (ctrl.action == ACT_LOAD);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_NO_INPUT: cond_hit = !in_valid;
            COND_DEN_ZERO: cond_hit = flags.den_zero;
            COND_GCD_BUSY: cond_hit = flags.gcd_busy;
            COND_DIV_MORE: cond_hit = !flags.div_last;
            COND_OUT_FULL: cond_hit = flags.out_full;
            default:       cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // An accepted beat always starts the program at the denominator check.
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pc_reg == STEP_CHECK)
        else $error("sequencer did not move to the check step after a beat");

    // A result write waits in place while the output register is occupied.
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.action == ACT_OUT_OK || ctrl.action == ACT_OUT_ERR) && flags.out_full
        |=> pc_reg == $past(pc_reg))
        else $error("result step left while the output register was full");

endmodule

### design/rau_datapath.sv
`timescale 1ns / 1ps

module rau_datapath import rau_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ctrl_word_t                       ctrl,
    input  logic                             in_valid,
    input  logic [OP_W-1:0]                  op,
    input  logic signed [OPERAND_BITS-1:0]   num_a,
    input  logic [OPERAND_BITS-2:0]          den_a,
    input  logic signed [OPERAND_BITS-1:0]   num_b,
    input  logic [OPERAND_BITS-2:0]          den_b,
    output dp_flags_t                        flags,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [2*OPERAND_BITS+1:0] res_num,
    output logic [2*OPERAND_BITS-3:0]        res_den,
    output logic                             status
);

    localparam int unsigned PROD_W = 2 * OPERAND_BITS;
    localparam int unsigned NUM_W  = 2 * OPERAND_BITS + 2;
    localparam int unsigned DEN_W  = 2 * OPERAND_BITS - 2;
    localparam int unsigned CNT_W  = $clog2(NUM_W + 1);
    localparam int unsigned K_W    = $clog2(NUM_W);

    // Operands
    logic [OP_W-1:0]                op_reg;
    logic signed [OPERAND_BITS-1:0] na_reg;
    logic [OPERAND_BITS-2:0]        da_reg;
    logic signed [OPERAND_BITS-1:0] nb_reg;
    logic [OPERAND_BITS-2:0]        db_reg;

    // Products and the unreduced fraction as sign and magnitude
    logic signed [PROD_W-1:0] t1_reg;
    logic signed [PROD_W-1:0] t2_reg;
    logic                     sign_reg;
    logic [NUM_W-1:0]         u_reg;
    logic [NUM_W-1:0]         v_reg;

    // Binary GCD and restoring divider
    logic [NUM_W-1:0] x_reg;
    logic [NUM_W-1:0] y_reg;
    logic [K_W-1:0]   k_reg;
    logic [NUM_W-1:0] d_reg;
    logic [NUM_W-1:0] q_reg;
    logic [NUM_W-1:0] r_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [NUM_W-1:0]  res_num_reg;
    logic [DEN_W-1:0]         res_den_reg;
    logic                     status_reg;

    logic                           load;
    logic                           is_mul;
    logic                           is_sub;
    logic signed [OPERAND_BITS-1:0] mul_a;
    logic signed [OPERAND_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W:0]         t1x;
    logic signed [PROD_W:0]         t2x;
    logic signed [PROD_W:0]         sum_c;
    logic [PROD_W:0]                mag_c;
    logic [NUM_W-1:0]               xy_diff;
    logic [NUM_W-1:0]               yx_diff;
    logic [NUM_W:0]                 rem_shift;
    logic [NUM_W:0]                 trial;
    logic                           out_write;

    assign load      = (ctrl.action == ACT_LOAD) && in_valid;
    assign is_mul    = op_reg[OP_MUL_BIT];
    assign is_sub    = (op_reg == OP_SUB);
    assign out_write = (ctrl.action == ACT_OUT_OK || ctrl.action == ACT_OUT_ERR)
                       && !out_valid_reg;

    // One shared signed multiplier; denominators enter with a zero sign bit.
    always_comb
    begin
        unique case (ctrl.action)
            ACT_MUL_T1:
            begin
                mul_a = na_reg;
                mul_b = is_mul ? nb_reg : $signed({1'b0, db_reg});
            end
            ACT_MUL_T2:
            begin
                mul_a = nb_reg;
                mul_b = $signed({1'b0, da_reg});
            end
            default:
            begin
                mul_a = $signed({1'b0, da_reg});
                mul_b = $signed({1'b0, db_reg});
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign t1x   = {t1_reg[PROD_W-1], t1_reg};
    assign t2x   = {t2_reg[PROD_W-1], t2_reg};
    assign sum_c = is_mul ? t1x : (is_sub ? t1x - t2x : t1x + t2x);
    assign mag_c = sum_c[PROD_W] ? unsigned'(-sum_c) : unsigned'(sum_c);

    assign xy_diff   = x_reg - y_reg;
    assign yx_diff   = y_reg - x_reg;
    assign rem_shift = {r_reg, q_reg[NUM_W-1]};
    assign trial     = rem_shift - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        unique case (ctrl.action)
            ACT_LOAD:
            begin
                if (load)
                begin
                    op_reg <= op;
                    na_reg <= num_a;
                    da_reg <= den_a;
                    nb_reg <= num_b;
                    db_reg <= den_b;
                end
            end
            ACT_MUL_T1:  t1_reg <= prod;
            ACT_MUL_T2:  t2_reg <= prod;
            ACT_MUL_DEN: v_reg  <= NUM_W'($unsigned(prod));
            ACT_COMBINE:
            begin
                sign_reg <= sum_c[PROD_W];
                u_reg    <= {1'b0, mag_c};
            end
            ACT_GCD_INIT:
            begin
                x_reg <= u_reg;
                y_reg <= v_reg;
                k_reg <= '0;
            end
            ACT_GCD_STEP:
            begin
                if (x_reg != '0)
                begin
                    priority if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + K_W'(1);
                    end
                    else if (!x_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_reg <= y_reg >> 1;
                    end
                    else if (x_reg >= y_reg)
                    begin
                        // Both odd, so the difference is even.
                        x_reg <= xy_diff >> 1;
                    end
                    else
                    begin
                        y_reg <= yx_diff >> 1;
                    end
                end
            end
            ACT_DIV_INIT:
            begin
                d_reg   <= y_reg << k_reg;
                q_reg   <= u_reg;
                r_reg   <= '0;
                cnt_reg <= CNT_W'(NUM_W);
            end
            ACT_DIV_STEP:
            begin
                if (!trial[NUM_W])
                begin
                    r_reg <= trial[NUM_W-1:0];
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= rem_shift[NUM_W-1:0];
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ACT_DIV_NEXT:
            begin
                u_reg   <= q_reg;
                q_reg   <= v_reg;
                r_reg   <= '0;
                cnt_reg <= CNT_W'(NUM_W);
            end
            ACT_OUT_OK:
            begin
                if (out_write)
                begin
                    res_num_reg <= sign_reg ? -$signed(u_reg) : $signed(u_reg);
                    res_den_reg <= q_reg[DEN_W-1:0];
                    status_reg  <= STATUS_OK;
                end
            end
            ACT_OUT_ERR:
            begin
                if (out_write)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= STATUS_DEN_ZERO;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign flags.den_zero = (da_reg == '0) || (db_reg == '0);
    assign flags.gcd_busy = (x_reg != '0);
    assign flags.div_last = (cnt_reg == CNT_W'(1));
    assign flags.out_full = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

    // The reduction divides by a common factor, so nothing may remain.
    a_exact_num_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.action == ACT_DIV_NEXT |-> r_reg == '0)
        else $error("numerator not divisible by the computed GCD");

    a_exact_den_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_write && ctrl.action == ACT_OUT_OK |-> r_reg == '0)
        else $error("denominator not divisible by the computed GCD");

    a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_OK |-> res_den_reg != '0)
        else $error("reduced denominator is zero on a good result");

endmodule

### design/rational_arithmetic_unit.sv
`timescale 1ns / 1ps

// Rational arithmetic unit: adds, subtracts or multiplies two fractions and
// returns the result in lowest terms with a positive denominator.
// The operands channel carries one fraction pair and the operation per beat;
// the result channel carries the reduced numerator, denominator and status.
// A beat with a zero denominator returns status 1 with a zero fraction.
// Work is run by a small microprogram: three products on one shared
// multiplier, a binary GCD of numerator magnitude and denominator at one
// step per cycle, then two restoring divisions by that GCD at one quotient
// bit per cycle. The number of GCD steps depends on the data. The next
// operands beat is taken after the result is written and the program has
// returned to idle. A beat with a zero denominator goes from the check
// step straight to the error result and skips the arithmetic.
// One item is in work at a time.
// The result sits in an output register, so a new operands beat is taken
// while an earlier result still waits; if the receiver stalls, the next
// result waits in the program until the register empties.
// Reset clears the program counter and the output valid flag.

module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rau_in_if.sink    operands,
    rau_out_if.source result
);

    ctrl_word_t ctrl;
    dp_flags_t  flags;
    logic       in_ready;

    assign operands.ready = in_ready;

    // Sequencer: step counter, microprogram table and jump logic.
    rau_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operands.valid),
        .flags    (flags),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // Datapath: operand capture, multiplier, GCD, divider and the output
    // register that decouples the result channel from the program.
    rau_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (operands.valid),
        .op        (operands.op),
        .num_a     (operands.num_a),
        .den_a     (operands.den_a),
        .num_b     (operands.num_b),
        .den_b     (operands.den_b),
        .flags     (flags),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .res_num   (result.res_num),
        .res_den   (result.res_den),
        .status    (result.status)
    );

endmodule
